// File: sv/crp_pkg.sv
// Shared types, constants and the CRC byte step of the checked record parser.
package crp_pkg;

   localparam int HDR_BYTES           = 12;
   localparam int FTR_BYTES           = 28;
   localparam int DEFAULT_MAX_PAYLOAD = 65536;
   localparam int LIMIT_W             = 17;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 17'h10000;
   localparam logic [31:0]        CRC_POLY       = 32'hEDB88320;
   localparam logic [31:0]        CRC_INIT       = 32'hFFFFFFFF;
   localparam logic [31:0]        FLAG_PENDING   = 32'h00000000;
   localparam logic [31:0]        FLAG_PROCESSED = 32'hFFFFFFFF;
   localparam logic [7:0]         VERSION_LSB    = 8'h01;

   // Footer field offsets, relative to the end of the payload
   localparam logic [4:0] OFF_VERSION = 5'd4;
   localparam logic [4:0] OFF_CRC     = 5'd8;
   localparam logic [4:0] OFF_REQUEST = 5'd12;
   localparam logic [4:0] OFF_OWNER   = 5'd20;
   localparam logic [4:0] OFF_END     = 5'd28;

   localparam logic [7:0] MAGIC [4] = '{8'h44, 8'h50, 8'h48, 8'h53};

   typedef enum logic [1:0] {
      ST_PENDING   = 2'd0,
      ST_PROCESSED = 2'd1,
      ST_INVALID   = 2'd2,
      ST_LIMIT     = 2'd3
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   // Record fields as they stand after the final byte, handed to the verdict logic
   typedef struct packed {
      logic [31:0] flag_word;
      logic [31:0] payload_length;
      logic [31:0] running_crc;
      logic [31:0] stored_crc;
      logic        request_zero;
      logic        footer_bad;
   } rec_check_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'b0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

// File: sv/crp_req_if.sv
// Input channel of the checked record parser: one record byte per beat.
interface crp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// File: sv/crp_rsp_if.sv
// Result channel of the checked record parser: payload bytes and the final verdict.
interface crp_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [7:0]         payload_byte;
   logic [1:0]         status;
   logic signed [31:0] score;
   logic [63:0]        request_id;
   logic [63:0]        owner_id;

   modport source (output valid, output kind, output payload_byte, output status,
                   output score, output request_id, output owner_id, input ready);
   modport sink   (input valid, input kind, input payload_byte, input status,
                   input score, input request_id, input owner_id, output ready);
endinterface

// File: sv/crp_verdict.sv
// Ordered verdict checks on a completed record.
module crp_verdict #(
   parameter int MAX_PAYLOAD_BYTES = crp_pkg::DEFAULT_MAX_PAYLOAD,
   parameter int CNT_W             = 17
) (
   input  logic [CNT_W-1:0]               size,
   input  crp_pkg::rec_check_type         rec,
   input  logic [crp_pkg::LIMIT_W-1:0]    limit,
   output crp_pkg::status_type            status
);
   import crp_pkg::*;

   localparam int SIZE_MIN = HDR_BYTES + FTR_BYTES;
   localparam int SIZE_MAX = HDR_BYTES + FTR_BYTES + MAX_PAYLOAD_BYTES;

   logic        size_bad;
   logic        header_bad;
   logic        flag_bad;
   logic [33:0] size_want;
   logic        crc_bad;

   always_comb begin
      size_bad   = (size < CNT_W'(SIZE_MIN)) || (size > CNT_W'(SIZE_MAX));
      flag_bad   = (rec.flag_word != FLAG_PENDING) && (rec.flag_word != FLAG_PROCESSED);
      size_want  = 34'(rec.payload_length) + 34'(SIZE_MIN);
      header_bad = flag_bad
                || (rec.payload_length > 32'(MAX_PAYLOAD_BYTES))
                || (rec.payload_length[1:0] != 2'b00)
                || (34'(size) != size_want);
      crc_bad    = rec.stored_crc != ~rec.running_crc;

      if (size_bad || header_bad) begin
         status = ST_INVALID;
      end else if (rec.payload_length > 32'(limit)) begin
         status = ST_LIMIT;
      end else if (rec.footer_bad || rec.request_zero || crc_bad) begin
         status = ST_INVALID;
      end else if (rec.flag_word == FLAG_PENDING) begin
         status = ST_PENDING;
      end else begin
         status = ST_PROCESSED;
      end
   end

endmodule

// File: sv/checked_record_parser.sv
// Checked record parser top level: field capture, CRC and result register.
// The block takes record bytes and, in the cycle after one is taken, puts a
// passed-through payload byte or the verdict on the final byte into a single output
// register; other bytes give no result. A new byte is taken in every cycle in which
// that register is empty or being drained, so the sustained rate is one byte per
// cycle while results are taken. All record state clears with the verdict, so the
// byte after a final byte starts a new record. There is no clearing pass after
// reset. The limit register may be written at any idle time.
module checked_record_parser #(
   parameter int MAX_PAYLOAD_BYTES = crp_pkg::DEFAULT_MAX_PAYLOAD
) (
   input  logic                         clock,
   input  logic                         reset,
   crp_req_if.sink                      req_bus,
   crp_rsp_if.source                    rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [crp_pkg::LIMIT_W-1:0]  csr_wr_data
);
   import crp_pkg::*;

   localparam int COUNT_CAP = HDR_BYTES + FTR_BYTES + MAX_PAYLOAD_BYTES + 1;
   localparam int CNT_W     = $clog2(COUNT_CAP + 1);

   logic [LIMIT_W-1:0] limit_ff;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic [31:0]        crc_ff,    crc_in;
   logic [31:0]        flag_ff,   flag_in;
   logic [31:0]        score_ff,  score_in;
   logic [31:0]        len_ff,    len_in;
   logic [31:0]        scrc_ff,   scrc_in;
   logic [63:0]        req_ff,    req_in;
   logic [63:0]        own_ff,    own_in;
   logic               fbad_ff,   fbad_in;

   logic               out_valid_ff;
   kind_type           kind_ff;
   logic [7:0]         pbyte_ff;
   status_type         status_ff;
   logic [31:0]        oscore_ff;
   logic [63:0]        oreq_ff;
   logic [63:0]        oown_ff;

   logic               accept;
   logic [7:0]         b;
   logic [32:0]        pos_w;
   logic [32:0]        pend;
   logic [32:0]        off;
   logic [4:0]         off_lo;
   logic [4:0]         lane_req;
   logic [4:0]         lane_own;
   logic               in_body;
   logic               pass;
   logic               in_footer;
   logic               in_crc;
   status_type         verdict;
   rec_check_type      rec;

   assign req_bus.ready = !out_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.data_byte;

   always_comb begin
      flag_in  = flag_ff;
      score_in = score_ff;
      len_in   = len_ff;
      scrc_in  = scrc_ff;
      req_in   = req_ff;
      own_in   = own_ff;
      fbad_in  = fbad_ff;

      pos_w     = 33'(count_ff);
      pend      = {1'b0, len_ff} + 33'(HDR_BYTES);
      in_body   = count_ff >= CNT_W'(HDR_BYTES);
      pass      = in_body && (pos_w < pend);
      off       = pos_w - pend;
      in_footer = in_body && !pass && (off < 33'(OFF_END));
      off_lo    = off[4:0];
      lane_req  = off_lo - OFF_REQUEST;
      lane_own  = off_lo - OFF_OWNER;
      in_crc    = count_ff >= CNT_W'(4);

      if (count_ff < CNT_W'(4)) begin
         flag_in[{count_ff[1:0], 3'b000} +: 8] = b;
      end else if (count_ff < CNT_W'(8)) begin
         score_in[{count_ff[1:0], 3'b000} +: 8] = b;
      end else if (!in_body) begin
         len_in[{count_ff[1:0], 3'b000} +: 8] = b;
      end else if (in_footer) begin
         if (off_lo < OFF_VERSION) begin
            if (b != MAGIC[off_lo[1:0]]) fbad_in = 1'b1;
         end else if (off_lo < OFF_CRC) begin
            if (b != ((off_lo == OFF_VERSION) ? VERSION_LSB : 8'h00)) fbad_in = 1'b1;
         end else if (off_lo < OFF_REQUEST) begin
            scrc_in[{off_lo[1:0], 3'b000} +: 8] = b;
            in_crc = 1'b0;
         end else if (off_lo < OFF_OWNER) begin
            req_in[{lane_req[2:0], 3'b000} +: 8] = b;
         end else begin
            own_in[{lane_own[2:0], 3'b000} +: 8] = b;
         end
      end

      crc_in   = in_crc ? crc_byte(crc_ff, b) : crc_ff;
      count_in = (count_ff < CNT_W'(COUNT_CAP)) ? count_ff + CNT_W'(1) : CNT_W'(COUNT_CAP);

      rec.flag_word      = flag_in;
      rec.payload_length = len_in;
      rec.running_crc    = crc_in;
      rec.stored_crc     = scrc_in;
      rec.request_zero   = req_in == 64'd0;
      rec.footer_bad     = fbad_in;
   end

   crp_verdict #(
      .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
      .CNT_W             (CNT_W)
   ) u_verdict (
      .size   (count_in),
      .rec    (rec),
      .limit  (limit_ff),
      .status (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // Record state: advance on every beat, clear after the final byte
   always_ff @(posedge clock) begin
      if (reset || (accept && req_bus.last)) begin
         count_ff <= '0;
         crc_ff   <= CRC_INIT;
         flag_ff  <= '0;
         score_ff <= '0;
         len_ff   <= '0;
         scrc_ff  <= '0;
         req_ff   <= '0;
         own_ff   <= '0;
         fbad_ff  <= 1'b0;
      end else if (accept) begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
         flag_ff  <= flag_in;
         score_ff <= score_in;
         len_ff   <= len_in;
         scrc_ff  <= scrc_in;
         req_ff   <= req_in;
         own_ff   <= own_in;
         fbad_ff  <= fbad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= req_bus.last || pass;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Result payload: verdict wins over pass-through on the final byte
   always_ff @(posedge clock) begin
      if (accept) begin
         if (req_bus.last) begin
            kind_ff   <= KIND_VERDICT;
            pbyte_ff  <= 8'h00;
            status_ff <= verdict;
            oscore_ff <= score_in;
            oreq_ff   <= req_in;
            oown_ff   <= own_in;
         end else begin
            kind_ff   <= KIND_PAYLOAD;
            pbyte_ff  <= b;
            status_ff <= ST_PENDING;
            oscore_ff <= '0;
            oreq_ff   <= '0;
            oown_ff   <= '0;
         end
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.kind         = kind_ff;
   assign rsp_bus.payload_byte = pbyte_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.score        = oscore_ff;
   assign rsp_bus.request_id   = oreq_ff;
   assign rsp_bus.owner_id     = oown_ff;

endmodule

// File: sv/crp_checker.sv
// Port-level assertions for the checked record parser, bound to the top level.
module crp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [7:0]  rsp_payload_byte,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_score,
   input logic [63:0] rsp_request_id,
   input logic [63:0] rsp_owner_id
);
   import crp_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind)
                                     && $stable(rsp_payload_byte) && $stable(rsp_status)))
      else $error("result beat changed while stalled");

   // Input stalls only behind a blocked result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without a blocked result");

   // A final byte yields a verdict beat on the next cycle
   a_verdict: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> (rsp_valid && rsp_kind == KIND_VERDICT))
      else $error("final byte did not produce a verdict");

   // Pass-through beats carry only the byte
   a_pass_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_PAYLOAD) |-> (rsp_status == ST_PENDING
         && rsp_score == 32'd0 && rsp_request_id == 64'd0 && rsp_owner_id == 64'd0))
      else $error("payload beat carries verdict fields");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind checked_record_parser crp_checker u_crp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_last         (req_bus.last),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_kind         (rsp_bus.kind),
   .rsp_payload_byte (rsp_bus.payload_byte),
   .rsp_status       (rsp_bus.status),
   .rsp_score        (rsp_bus.score),
   .rsp_request_id   (rsp_bus.request_id),
   .rsp_owner_id     (rsp_bus.owner_id)
);

// File: tb/tb_checked_record_parser.sv
// Self-checking testbench for the checked record parser: record stimulus, prediction, checks.
`timescale 1ns / 1ps

module tb_checked_record_parser;
   import crp_pkg::*;

   localparam int PAYLOAD_MAX   = DEFAULT_MAX_PAYLOAD;
   localparam int COUNT_CAP     = HDR_BYTES + FTR_BYTES + PAYLOAD_MAX + 1;
   localparam int QUIET_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } feed_item_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload;
      status_type  status;
      logic [31:0] score;
      logic [63:0] req_id;
      logic [63:0] owner_id;
   } result_beat_type;

   typedef enum int {
      FLT_NONE, FLT_MAGIC, FLT_VERSION, FLT_CRC, FLT_REQ_ZERO, FLT_FLIP, FLT_CUT, FLT_EXTEND
   } fault_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [LIMIT_W-1:0]  csr_wr_data;

   crp_req_if req_bus ();
   crp_rsp_if rsp_bus ();

   checked_record_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   feed_item_type   record_bytes[$];
   result_beat_type owed_beats[$];

   // Predictor copy of the record state and the limit register
   logic [16:0]  rec_count;
   logic [31:0]  rec_crc;
   logic [31:0]  rec_flags;
   logic [31:0]  rec_score;
   logic [31:0]  rec_len;
   logic [31:0]  rec_stored_crc;
   logic [63:0]  rec_req;
   logic [63:0]  rec_owner;
   logic         rec_footer_bad;
   logic [16:0]  limit_now;

   bit  idle_on;
   int  send_gap;
   int  take_gap;
   int  quiet_cycles;
   int  fail_count;
   int  bytes_queued;
   int  bytes_sent;
   int  payload_seen;
   int  verdict_tally[4];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h0, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic void clear_record();
      rec_count      = '0;
      rec_crc        = CRC_INIT;
      rec_flags      = '0;
      rec_score      = '0;
      rec_len        = '0;
      rec_stored_crc = '0;
      rec_req        = '0;
      rec_owner      = '0;
      rec_footer_bad = 1'b0;
   endfunction

   function automatic status_type judge();
      longint unsigned rec_size, len;
      rec_size = rec_count;
      len      = rec_len;
      if (rec_size < HDR_BYTES + FTR_BYTES || rec_size > HDR_BYTES + FTR_BYTES + PAYLOAD_MAX)
         return ST_INVALID;
      if ((rec_flags != FLAG_PENDING && rec_flags != FLAG_PROCESSED) || len > PAYLOAD_MAX ||
          len[1:0] != 2'b00 || rec_size != HDR_BYTES + FTR_BYTES + len)
         return ST_INVALID;
      if (len > limit_now) return ST_LIMIT;
      if (rec_footer_bad) return ST_INVALID;
      if (rec_req == '0 || rec_stored_crc != ~rec_crc) return ST_INVALID;
      return (rec_flags == FLAG_PENDING) ? ST_PENDING : ST_PROCESSED;
   endfunction

   // Advance the record state by one accepted byte and queue what it owes
   task automatic parse_byte(input logic [7:0] b, input logic fin);
      int              pos, off;
      longint unsigned pend;
      bit              passes, crc_on;
      result_beat_type r;
      pos    = rec_count;
      passes = 1'b0;
      crc_on = (pos >= 4);
      if (pos < 4) rec_flags[8*pos +: 8] = b;
      else if (pos < 8) rec_score[8*(pos-4) +: 8] = b;
      else if (pos < HDR_BYTES) rec_len[8*(pos-8) +: 8] = b;
      else begin
         pend = longint'(HDR_BYTES) + longint'(rec_len);
         if (longint'(pos) < pend) passes = 1'b1;
         else begin
            off = pos - int'(pend);
            if (off < OFF_VERSION) begin
               if (b != MAGIC[off]) rec_footer_bad = 1'b1;
            end else if (off < OFF_CRC) begin
               if (b != ((off == OFF_VERSION) ? VERSION_LSB : 8'h00)) rec_footer_bad = 1'b1;
            end else if (off < OFF_REQUEST) begin
               rec_stored_crc[8*(off-OFF_CRC) +: 8] = b;
               crc_on = 1'b0;
            end else if (off < OFF_OWNER) rec_req[8*(off-OFF_REQUEST) +: 8] = b;
            else if (off < OFF_END) rec_owner[8*(off-OFF_OWNER) +: 8] = b;
         end
      end
      if (crc_on) rec_crc = crc_step(rec_crc, b);
      rec_count = (rec_count < COUNT_CAP) ? rec_count + 17'd1 : 17'(COUNT_CAP);

      if (fin) begin
         r.kind     = KIND_VERDICT;
         r.payload  = 8'h00;
         r.status   = judge();
         r.score    = rec_score;
         r.req_id   = rec_req;
         r.owner_id = rec_owner;
         owed_beats.insert(owed_beats.size(), r);
         clear_record();
      end else if (passes) begin
         r.kind     = KIND_PAYLOAD;
         r.payload  = b;
         r.status   = ST_PENDING;
         r.score    = '0;
         r.req_id   = '0;
         r.owner_id = '0;
         owed_beats.insert(owed_beats.size(), r);
      end
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Build one record, apply the chosen fault, and queue its bytes
   task automatic queue_record(input logic [31:0] flags, input logic [31:0] score,
                               input logic [31:0] len_field, input int pay_n,
                               input fault_type fault);
      logic [7:0]  rec[$];
      logic [63:0] rid, oid;
      logic [31:0] crc;
      int          crc_at, keep;
      rid = {$urandom, $urandom};
      oid = {$urandom, $urandom};
      if (fault == FLT_REQ_ZERO) rid = '0;
      else if (rid == '0) rid = 64'd1;
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), flags[8*i +: 8]);
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), score[8*i +: 8]);
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), len_field[8*i +: 8]);
      repeat (pay_n) rec.insert(rec.size(), 8'($urandom));
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), MAGIC[i]);
      rec.insert(rec.size(), VERSION_LSB);
      repeat (3) rec.insert(rec.size(), 8'h00);
      crc_at = rec.size();
      repeat (4) rec.insert(rec.size(), 8'h00);
      for (int i = 0; i < 8; i++) rec.insert(rec.size(), rid[8*i +: 8]);
      for (int i = 0; i < 8; i++) rec.insert(rec.size(), oid[8*i +: 8]);
      if (fault == FLT_MAGIC)
         rec[crc_at - 8 + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
      if (fault == FLT_VERSION)
         rec[crc_at - 4 + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
      crc = CRC_INIT;
      for (int i = 4; i < rec.size(); i++)
         if (i < crc_at || i >= crc_at + 4) crc = crc_step(crc, rec[i]);
      crc = ~crc;
      for (int i = 0; i < 4; i++) rec[crc_at + i] = crc[8*i +: 8];
      case (fault)
         FLT_CRC:    rec[crc_at + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
         FLT_FLIP:   rec[$urandom_range(0, rec.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
         FLT_CUT: begin
            keep = $urandom_range(1, rec.size() - 1);
            while (rec.size() > keep) void'(rec.pop_back());
         end
         // extra bytes past the footer make the size disagree with the length
         FLT_EXTEND: repeat ($urandom_range(2, 8)) rec.insert(rec.size(), 8'($urandom));
         default: ;
      endcase
      foreach (rec[i])
         record_bytes.insert(record_bytes.size(), feed_item_type'{rec[i], i == rec.size() - 1});
      bytes_queued += rec.size();
   endtask

   task automatic queue_noise(input int n);
      for (int i = 0; i < n; i++)
         record_bytes.insert(record_bytes.size(), feed_item_type'{8'($urandom), i == n - 1});
      bytes_queued += n;
   endtask

   task automatic queue_random(input int n_bytes);
      int          goal, pick, pay_n;
      logic [31:0] flags, len_field;
      fault_type   fault;
      goal = bytes_queued + n_bytes;
      while (bytes_queued < goal) begin
         if ($urandom_range(0, 99) < 5) begin
            queue_noise($urandom_range(1, 60));
            continue;
         end
         pick  = $urandom_range(0, 99);
         flags = (pick < 45) ? FLAG_PENDING : (pick < 90) ? FLAG_PROCESSED : 32'($urandom);
         pay_n = ($urandom_range(0, 15) == 0) ? 4 * $urandom_range(5, 60)
                                              : 4 * $urandom_range(0, 4);
         len_field = pay_n;
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            pay_n     = $urandom_range(0, 19);
            len_field = pay_n;
         end else if (pick < 7) len_field = $urandom_range(0, 24);
         else if (pick < 9) len_field = $urandom;
         fault = ($urandom_range(0, 99) < 65) ? FLT_NONE
               : fault_type'($urandom_range(int'(FLT_MAGIC), int'(FLT_EXTEND)));
         queue_record(flags, $urandom, len_field, pay_n, fault);
      end
   endtask

   // Hold until every queued byte is in and every owed beat is out
   task automatic settle();
      while (record_bytes.size() != 0 || req_bus.valid || owed_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      limit_now = v;
   endtask

   always @(posedge clock) begin : drive_req
      feed_item_type item;
      logic          busy;
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.data_byte <= 8'h00;
         req_bus.last      <= 1'b0;
         send_gap = 0;
      end else begin
         busy = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            parse_byte(req_bus.data_byte, req_bus.last);
            bytes_sent++;
            busy = 1'b0;
         end
         if (!busy) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (record_bytes.size() > 0 && idle_on && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 6);
               req_bus.valid <= 1'b0;
            end else if (record_bytes.size() > 0) begin
               item = record_bytes.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.data_byte <= item.data;
               req_bus.last      <= item.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      result_beat_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (owed_beats.size() == 0) begin
               $error("unexpected result beat: kind %0d payload_byte %0h status %0d",
                      rsp_bus.kind, rsp_bus.payload_byte, rsp_bus.status);
               fail_count++;
            end else begin
               want = owed_beats.pop_front();
               check_field("kind", 64'(want.kind), 64'(rsp_bus.kind));
               check_field("payload_byte", 64'(want.payload), 64'(rsp_bus.payload_byte));
               check_field("status", 64'(want.status), 64'(rsp_bus.status));
               check_field("score", {32'h0, want.score}, {32'h0, rsp_bus.score});
               check_field("request_id", want.req_id, rsp_bus.request_id);
               check_field("owner_id", want.owner_id, rsp_bus.owner_id);
               if (want.kind == KIND_VERDICT) verdict_tally[want.status]++;
               else payload_seen++;
            end
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            take_gap = $urandom_range(0, 6);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.last      = 1'b0;
      rsp_bus.ready     = 1'b0;
      idle_on           = 1'b1;
      quiet_cycles      = 0;
      fail_count        = 0;
      bytes_queued      = 0;
      bytes_sent        = 0;
      payload_seen      = 0;
      foreach (verdict_tally[i]) verdict_tally[i] = 0;
      limit_now         = LIMIT_RESET;
      clear_record();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Mid-size payload with the most negative score, then the smallest record
      queue_record(FLAG_PENDING, 32'h8000_0000, 32'd64, 64, FLT_NONE);
      queue_record(FLAG_PROCESSED, 32'h7FFF_FFFF, 32'd0, 0, FLT_NONE);
      settle();
      queue_record(FLAG_PENDING, $urandom, 32'd8, 8, FLT_MAGIC);
      queue_record(FLAG_PROCESSED, $urandom, 32'd4, 4, FLT_VERSION);
      queue_record(FLAG_PENDING, $urandom, 32'd4, 4, FLT_CRC);
      queue_record(FLAG_PROCESSED, $urandom, 32'd0, 0, FLT_REQ_ZERO);
      queue_record(32'h0000_0001, $urandom, 32'd4, 4, FLT_NONE);
      queue_record(FLAG_PENDING, $urandom, 32'd5, 5, FLT_NONE);
      queue_record(FLAG_PENDING, $urandom, 32'd8, 4, FLT_NONE);
      // oversized length: last byte lands inside the payload
      queue_record(FLAG_PENDING, $urandom, 32'hFFFF_FFFC, 4, FLT_NONE);
      queue_record(FLAG_PROCESSED, $urandom, PAYLOAD_MAX + 4, 0, FLT_NONE);
      queue_noise(1);
      queue_noise(HDR_BYTES + FTR_BYTES - 1);
      queue_record(FLAG_PROCESSED, $urandom, 32'd8, 8, FLT_EXTEND);
      settle();

      write_limit('0);
      queue_random(100);
      settle();
      write_limit('1);
      queue_random(100);
      settle();
      write_limit(17'd12);
      queue_random(100);
      settle();
      write_limit(17'($urandom_range(0, 20)));
      queue_random(100);
      settle();
      write_limit(LIMIT_RESET);
      idle_on = 1'b0;
      queue_random(120);
      settle();

      $display("Sent %0d record bytes under five limit settings; %0d payload bytes returned",
               bytes_sent, payload_seen);
      $display("Verdicts: %0d pending, %0d processed, %0d invalid, %0d over limit",
               verdict_tally[ST_PENDING], verdict_tally[ST_PROCESSED],
               verdict_tally[ST_INVALID], verdict_tally[ST_LIMIT]);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
